// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the dimmer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion of a property, switched off while reset is low.
`define TDRP_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Clocked implication: when the condition holds, the consequence must hold as well.
`define TDRP_ASSERT_IMP(label, clk_sig, rst_n_sig, cond, conseq, msg) \
	`TDRP_ASSERT(label, clk_sig, rst_n_sig, (cond) |-> (conseq), msg)

`endif

// ===== rtl/core/tdrp_pkg.sv =====
// Package of the dimmer core: event codes, power limits and the firing delay lookup.
`default_nettype none
package tdrp_pkg;

	typedef enum logic [2:0] {
		OP_ZERO_CROSS = 3'd0,
		OP_SET_POWER  = 3'd1,
		OP_STEP_POWER = 3'd2,
		OP_ON         = 3'd3,
		OP_OFF        = 3'd4,
		OP_TOGGLE     = 3'd5
	} opcode_t;

	localparam logic [6:0] POWER_MAX = 7'd100;
	localparam int unsigned MAX_RAMP_SECONDS = 63;

	// Firing delay code for each power percent from 0 to 100.
	localparam logic [6:0] DELAY_LUT [101] = '{
		7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd17, 7'd18, 7'd19,
		7'd20, 7'd22, 7'd23, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
		7'd29, 7'd30, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd35, 7'd35, 7'd36,
		7'd37, 7'd37, 7'd38, 7'd39, 7'd39, 7'd40, 7'd41, 7'd41, 7'd42, 7'd43,
		7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49, 7'd50,
		7'd50, 7'd51, 7'd51, 7'd52, 7'd52, 7'd53, 7'd54, 7'd54, 7'd55, 7'd56,
		7'd56, 7'd57, 7'd58, 7'd58, 7'd59, 7'd60, 7'd60, 7'd61, 7'd62, 7'd62,
		7'd63, 7'd64, 7'd64, 7'd65, 7'd66, 7'd67, 7'd67, 7'd68, 7'd69, 7'd70,
		7'd70, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79,
		7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd87, 7'd89, 7'd90, 7'd93,
		7'd99
	};

	// Levels above full power have no entry and give a zero delay code.
	function automatic logic [6:0] delay_lookup(input logic [6:0] level);
		logic [6:0] code;
		if (level > POWER_MAX) begin
			code = 7'd0;
		end else begin
			code = DELAY_LUT[level];
		end
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/triac_dimmer_ramp_phase.sv =====
// Top level of the triac phase-angle dimmer with a linear soft ramp.
// The block takes one event item at a time and answers each with one status item.
// A mains zero crossing recomputes the applied power as
// start + (target_or_zero - start) * count / ramp_cycles, truncated toward zero,
// and looks the result up in the firing delay table. The multiply has a state of its own,
// and the divide by the ramp length is a restoring divider that produces one
// quotient bit per cycle; a zero crossing passes through the multiply, divide, finish
// and done states on its way from acceptance to the status item.
// Every other event updates the registers in the cycle it is accepted and sends its
// status item from the done state to the output register. The input side is ready again as soon
// as the status item sits in the output register, even while it waits to be taken.
// A status item that is not taken holds the next event in the done state until the
// output register frees up.
// The ramp register write is accepted only while the block is idle and no event item
// is offered, and it resets the ramp counter to full, which ends any ramp at once;
// a zero setting counts as one second.
`default_nettype none
module triac_dimmer_ramp_phase #(
	parameter int unsigned AC_FREQ = 50
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Event channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] opcode,
	input  wire logic [7:0] power_value,
	// Status channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      firing_delay,
	output logic [6:0]      applied_power,
	output logic [6:0]      target_power,
	output logic            is_on,
	// Ramp time register write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [5:0] ramp_seconds
);

	`include "assert_macros.svh"

	// Longest ramp in mains half cycles sets the counter width.
	localparam int unsigned MAX_CYCLES = tdrp_pkg::MAX_RAMP_SECONDS * 2 * AC_FREQ;
	localparam int unsigned CNT_W      = $clog2(MAX_CYCLES + 1);
	// The product of the level difference magnitude and the ramp count.
	localparam int unsigned PROD_W     = 7 + CNT_W;
	localparam int unsigned ITER_W     = $clog2(PROD_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cycles_q;
	logic [CNT_W-1:0]    ramp_count_q;
	logic [6:0]          applied_q;
	logic [6:0]          target_q;
	logic [6:0]          start_q;
	logic                step_up_q;
	logic                enabled_q;
	logic [6:0]          delay_q;

	// Divider working registers.
	logic [6:0]          mag_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   num_q;
	logic [CNT_W-1:0]    rem_q;
	logic [ITER_W-1:0]   iter_q;

	logic                out_valid_q;
	logic [6:0]          out_delay_q;
	logic [6:0]          out_applied_q;
	logic [6:0]          out_target_q;
	logic                out_on_q;

	logic                in_fire;
	logic [CNT_W-1:0]    cfg_cycles;
	logic [5:0]          secs_eff;
	logic [6:0]          eff_level;
	logic [CNT_W-1:0]    cnt_eff;
	logic signed [8:0]   diff;
	logic [CNT_W:0]      rem_shift;
	logic                sub_ok;
	logic [CNT_W:0]      rem_sub;
	logic [6:0]          quo;
	logic signed [9:0]   lvl_sum;
	logic [6:0]          lvl_clamped;
	logic [6:0]          set_level;
	logic                step_dir;
	logic                out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Ramp length in half cycles for a register write.
	assign secs_eff   = (ramp_seconds == 6'd0) ? 6'd1 : ramp_seconds;
	assign cfg_cycles = CNT_W'(secs_eff) * CNT_W'(2 * AC_FREQ);

	// Operands of the ramp equation, taken when a zero crossing is accepted.
	assign eff_level = enabled_q ? target_q : 7'd0;
	assign cnt_eff   = (ramp_count_q > cycles_q) ? cycles_q : ramp_count_q;
	assign diff      = $signed({2'b00, eff_level}) - $signed({2'b00, start_q});

	// One restoring divide step: shift in the next dividend bit and try the subtract.
	assign rem_shift = {rem_q, num_q[PROD_W-1]};
	assign sub_ok    = (rem_shift >= {1'b0, cycles_q});
	assign rem_sub   = rem_shift - {1'b0, cycles_q};

	// The quotient never exceeds the difference magnitude, so seven bits hold it.
	assign quo     = num_q[6:0];
	assign lvl_sum = neg_q ? ($signed({3'b000, start_q}) - $signed({3'b000, quo}))
	                       : ($signed({3'b000, start_q}) + $signed({3'b000, quo}));

	always_comb begin
		if (lvl_sum < 0) begin
			lvl_clamped = 7'd0;
		end else if (lvl_sum > $signed({3'b000, tdrp_pkg::POWER_MAX})) begin
			lvl_clamped = tdrp_pkg::POWER_MAX;
		end else begin
			lvl_clamped = lvl_sum[6:0];
		end
	end

	// Set power clamps the request to full power.
	assign set_level = (power_value > 8'd100) ? tdrp_pkg::POWER_MAX : power_value[6:0];

	// Direction turns down at full power and up at zero before a step.
	always_comb begin
		step_dir = step_up_q;
		if (target_q >= tdrp_pkg::POWER_MAX) begin
			step_dir = 1'b0;
		end
		if (target_q == 7'd0) begin
			step_dir = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cycles_q      <= CNT_W'(4 * AC_FREQ);
			ramp_count_q  <= CNT_W'(4 * AC_FREQ);
			applied_q     <= 7'd0;
			target_q      <= 7'd0;
			start_q       <= 7'd0;
			step_up_q     <= 1'b1;
			enabled_q     <= 1'b0;
			delay_q       <= 7'd0;
			mag_q         <= 7'd0;
			neg_q         <= 1'b0;
			cnt_q         <= '0;
			num_q         <= '0;
			rem_q         <= '0;
			iter_q        <= '0;
			out_valid_q   <= 1'b0;
			out_delay_q   <= 7'd0;
			out_applied_q <= 7'd0;
			out_target_q  <= 7'd0;
			out_on_q      <= 1'b0;
		end else begin
			// The output register fills from the done state and empties once its item is taken.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (opcode == tdrp_pkg::OP_ZERO_CROSS) ? ST_MUL : ST_DONE;
						case (opcode)
							tdrp_pkg::OP_ZERO_CROSS: begin
								mag_q   <= diff[8] ? 7'(-diff) : diff[6:0];
								neg_q   <= diff[8];
								cnt_q   <= cnt_eff;
							end
							tdrp_pkg::OP_SET_POWER: begin
								target_q     <= set_level;
								if (set_level >= tdrp_pkg::POWER_MAX) begin
									step_up_q <= 1'b0;
								end
								if (set_level == 7'd0) begin
									step_up_q <= 1'b1;
								end
								ramp_count_q <= '0;
								start_q      <= applied_q;
							end
							tdrp_pkg::OP_STEP_POWER: begin
								step_up_q <= step_dir;
								target_q  <= step_dir ? (target_q + 7'd1) : (target_q - 7'd1);
							end
							tdrp_pkg::OP_ON: begin
								enabled_q    <= 1'b1;
								ramp_count_q <= '0;
								start_q      <= applied_q;
							end
							tdrp_pkg::OP_OFF: begin
								enabled_q    <= 1'b0;
								ramp_count_q <= '0;
								start_q      <= applied_q;
							end
							tdrp_pkg::OP_TOGGLE: begin
								enabled_q    <= !enabled_q;
								ramp_count_q <= '0;
								start_q      <= applied_q;
							end
							default: begin
								// Unused codes only report the current status.
							end
						endcase
					end else if (cfg_valid && cfg_ready) begin
						// A ramp time write fills the counter, so the current ramp ends.
						cycles_q     <= cfg_cycles;
						ramp_count_q <= cfg_cycles;
					end
				end
				ST_MUL: begin
					num_q   <= PROD_W'(mag_q) * PROD_W'(cnt_q);
					rem_q   <= '0;
					iter_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sub_ok) begin
						rem_q <= rem_sub[CNT_W-1:0];
					end else begin
						rem_q <= rem_shift[CNT_W-1:0];
					end
					num_q  <= {num_q[PROD_W-2:0], sub_ok};
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(PROD_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					applied_q <= lvl_clamped;
					delay_q   <= tdrp_pkg::delay_lookup(lvl_clamped);
					if (ramp_count_q < cycles_q) begin
						ramp_count_q <= ramp_count_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_delay_q   <= delay_q;
						out_applied_q <= applied_q;
						out_target_q  <= target_q;
						out_on_q      <= enabled_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign firing_delay  = out_delay_q;
	assign applied_power = out_applied_q;
	assign target_power  = out_target_q;
	assign is_on         = out_on_q;

	// The ramp counter never runs past the ramp length.
	`TDRP_ASSERT(a_count_bounded, clk, arst_n, ramp_count_q <= cycles_q, "ramp count past ramp length")
	// The applied level always stays within the power range.
	`TDRP_ASSERT(a_level_bounded, clk, arst_n, applied_q <= tdrp_pkg::POWER_MAX, "applied level out of range")
	// The divider quotient can never exceed the level difference it scales.
	`TDRP_ASSERT_IMP(a_quo_bounded, clk, arst_n, state_q == ST_FIN, num_q <= PROD_W'(mag_q), "quotient too large")
	// Right after an item is taken, the block is busy in the following cycle.
	`TDRP_ASSERT_IMP(a_busy_after_accept, clk, arst_n, in_fire, ##1 !in_ready, "ready right after accept")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the triac dimmer ramp core, with a built-in predictor of its status items.

module tb;

	// Mains frequency of the instance, and the two event codes that the block must ignore.
	localparam int MAINS_HZ = 50;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// Quiet settle time that wait_idle adds after the last status item has come back.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1030;
	localparam int REPORT_LIMIT = 10;
	localparam int RAMP_PHASES = 8;

	// Firing delay code for each applied power percent, 0 to 100.
	localparam logic [6:0] FIRE_DELAY [0:100] = '{
		7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd17, 7'd18, 7'd19,
		7'd20, 7'd22, 7'd23, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
		7'd29, 7'd30, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd35, 7'd35, 7'd36,
		7'd37, 7'd37, 7'd38, 7'd39, 7'd39, 7'd40, 7'd41, 7'd41, 7'd42, 7'd43,
		7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49, 7'd50,
		7'd50, 7'd51, 7'd51, 7'd52, 7'd52, 7'd53, 7'd54, 7'd54, 7'd55, 7'd56,
		7'd56, 7'd57, 7'd58, 7'd58, 7'd59, 7'd60, 7'd60, 7'd61, 7'd62, 7'd62,
		7'd63, 7'd64, 7'd64, 7'd65, 7'd66, 7'd67, 7'd67, 7'd68, 7'd69, 7'd70,
		7'd70, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79,
		7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd87, 7'd89, 7'd90, 7'd93,
		7'd99
	};

	typedef struct packed {
		logic [6:0] delay;
		logic [6:0] applied;
		logic [6:0] target;
		logic       enabled;
	} status_t;

	// All inputs of the block start at known values.
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] opcode = 3'd0;
	logic [7:0] power_value = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] firing_delay;
	logic [6:0] applied_power;
	logic [6:0] target_power;
	logic       is_on;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [5:0] ramp_seconds = 6'd0;

	// Predicted dimmer state. The ramp counter starts full, at two seconds of half cycles.
	logic [5:0] ramp_setting = 6'd2;
	int         lvl_applied = 0;
	int         lvl_target = 0;
	int         lvl_start = 0;
	int         half_cycles = 2 * 2 * MAINS_HZ;
	bit         step_up = 1'b1;
	bit         output_on = 1'b0;
	logic [6:0] delay_now = 7'd0;

	// Status items predicted for accepted events, oldest first.
	status_t expected_status [$];
	int      mismatch_count = 0;

	// While set, neither the event sender nor the status receiver pauses.
	bit steady_run = 1'b0;

	triac_dimmer_ramp_phase #(
		.AC_FREQ(MAINS_HZ)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.power_value  (power_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.firing_delay (firing_delay),
		.applied_power(applied_power),
		.target_power (target_power),
		.is_on        (is_on),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.ramp_seconds (ramp_seconds)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Number of half cycles in one full ramp. A setting of zero counts as one second.
	function automatic int ramp_length();
		int secs;
		secs = ramp_setting;
		if (secs == 0) begin
			secs = 1;
		end
		return secs * 2 * MAINS_HZ;
	endfunction

	// The step direction turns down at full power and up at zero power.
	function automatic void settle_direction();
		if (lvl_target >= 100) begin
			step_up = 1'b0;
		end
		if (lvl_target == 0) begin
			step_up = 1'b1;
		end
	endfunction

	// Applies one accepted event to the predicted state and queues the status item it causes.
	task automatic advance_dimmer(input logic [2:0] op, input logic [7:0] pv);
		int      span;
		int      eff;
		int      cnt;
		int      lvl;
		bit      restart;
		status_t st;
		restart = 1'b0;
		case (op)
			tdrp_pkg::OP_ZERO_CROSS: begin
				// The applied level follows a straight line from the ramp start toward the
				// effective target; the signed quotient truncates toward zero, which matters
				// on downward ramps.
				span = ramp_length();
				eff = output_on ? lvl_target : 0;
				cnt = (half_cycles > span) ? span : half_cycles;
				lvl = lvl_start + ((eff - lvl_start) * cnt) / span;
				if (lvl < 0) begin
					lvl = 0;
				end
				if (lvl > 100) begin
					lvl = 100;
				end
				lvl_applied = lvl;
				delay_now = FIRE_DELAY[lvl];
				if (half_cycles < span) begin
					half_cycles++;
				end
			end
			tdrp_pkg::OP_SET_POWER: begin
				lvl_target = (pv > tdrp_pkg::POWER_MAX) ? tdrp_pkg::POWER_MAX : pv;
				settle_direction();
				restart = 1'b1;
			end
			tdrp_pkg::OP_STEP_POWER: begin
				// Stepping moves the target only; the ramp keeps running.
				settle_direction();
				lvl_target = step_up ? lvl_target + 1 : lvl_target - 1;
				lvl_target = lvl_target & 'h7F;
			end
			tdrp_pkg::OP_ON: begin
				output_on = 1'b1;
				restart = 1'b1;
			end
			tdrp_pkg::OP_OFF: begin
				output_on = 1'b0;
				restart = 1'b1;
			end
			tdrp_pkg::OP_TOGGLE: begin
				output_on = !output_on;
				restart = 1'b1;
			end
			default: begin
			end
		endcase
		if (restart) begin
			half_cycles = 0;
			lvl_start = lvl_applied;
		end
		st.delay = delay_now;
		st.applied = 7'(lvl_applied);
		st.target = 7'(lvl_target);
		st.enabled = output_on;
		expected_status.push_back(st);
	endtask

	// Sends one event item, with random idle cycles ahead of it unless a steady run is on.
	// Valid stays high after acceptance so that back-to-back items need no extra edge.
	task automatic send_event(input logic [2:0] op, input logic [7:0] pv);
		if (!steady_run) begin
			while ($urandom_range(99) < 33) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode <= op;
		power_value <= pv;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		advance_dimmer(op, pv);
	endtask

	// Lowers valid, waits until every predicted status item has come back, and then lets
	// the block settle so that a register write finds it idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_status.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the ramp time. The counter is set to full, so any ramp ends at once.
	task automatic write_ramp(input logic [5:0] secs);
		cfg_valid <= 1'b1;
		ramp_seconds <= secs;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		ramp_setting = secs;
		half_cycles = ramp_length();
	endtask

	// Right after reset, ignored codes and a zero crossing must report the reset state.
	task automatic test_reset_state();
		send_event(OP_SPARE_A, 8'hFF);
		send_event(OP_SPARE_B, 8'h00);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'hA5);
	endtask

	// Targets above full power are clamped, and the step direction reverses at both ends.
	task automatic test_power_limits();
		send_event(tdrp_pkg::OP_SET_POWER, 8'd255);
		send_event(tdrp_pkg::OP_STEP_POWER, 8'h5A);
		send_event(tdrp_pkg::OP_SET_POWER, 8'd0);
		send_event(tdrp_pkg::OP_STEP_POWER, 8'h00);
		send_event(tdrp_pkg::OP_STEP_POWER, 8'hFF);
		send_event(tdrp_pkg::OP_SET_POWER, 8'd101);
		send_event(tdrp_pkg::OP_STEP_POWER, 8'h01);
		send_event(tdrp_pkg::OP_SET_POWER, 8'd128);
	endtask

	// Switching on, off and toggling each restart the ramp from the applied level.
	task automatic test_switching();
		send_event(tdrp_pkg::OP_ON, 8'h00);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'h00);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'hFF);
		send_event(tdrp_pkg::OP_TOGGLE, 8'h33);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'hCC);
		send_event(tdrp_pkg::OP_TOGGLE, 8'h00);
		send_event(tdrp_pkg::OP_OFF, 8'h00);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'h7F);
	endtask

	// A ramp write ends the ramp at once; zero and the largest setting are tried as well.
	task automatic test_ramp_register();
		wait_idle();
		write_ramp(6'd1);
		send_event(tdrp_pkg::OP_ON, 8'h00);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'h00);
		wait_idle();
		write_ramp(6'd0);
		send_event(tdrp_pkg::OP_SET_POWER, 8'd57);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'h00);
		wait_idle();
		write_ramp(6'd63);
		send_event(tdrp_pkg::OP_ZERO_CROSS, 8'h00);
	endtask

	// Random bursts: one control event, or a run of steps, followed by a run of zero
	// crossings. Short ramp settings with long runs let ramps finish; long settings keep
	// ramps in flight. One phase runs with no idle cycles on either side.
	task automatic test_random_bursts();
		logic [5:0] settings [RAMP_PHASES];
		int         budget;
		int         sent;
		int         pick;
		int         run_len;
		settings = '{6'd1, 6'd0, 6'd2, 6'd60, 6'd63, 6'd1, 6'd2, 6'd5};
		settings[6] = 6'($urandom_range(3, 59));
		settings[7] = 6'($urandom_range(1, 10));
		budget = RANDOM_ITEMS / RAMP_PHASES;
		for (int p = 0; p < RAMP_PHASES; p++) begin
			wait_idle();
			write_ramp(settings[p]);
			steady_run = (p == 2);
			sent = 0;
			while (sent < budget) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					// Mostly in-range targets, with the full byte range now and then.
					if ($urandom_range(3) == 0) begin
						send_event(tdrp_pkg::OP_SET_POWER, 8'($urandom_range(255)));
					end else begin
						send_event(tdrp_pkg::OP_SET_POWER, 8'($urandom_range(100)));
					end
					sent++;
				end else if (pick < 45) begin
					run_len = $urandom_range(1, 12);
					repeat (run_len) send_event(tdrp_pkg::OP_STEP_POWER, 8'($urandom_range(255)));
					sent += run_len;
				end else if (pick < 60) begin
					send_event(tdrp_pkg::OP_ON, 8'($urandom_range(255)));
					sent++;
				end else if (pick < 72) begin
					send_event(tdrp_pkg::OP_OFF, 8'($urandom_range(255)));
					sent++;
				end else if (pick < 88) begin
					send_event(tdrp_pkg::OP_TOGGLE, 8'($urandom_range(255)));
					sent++;
				end else if (pick < 92) begin
					// Ignored codes are noise and do not count toward the phase.
					send_event($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B,
						8'($urandom_range(255)));
				end
				if ($urandom_range(7) == 0) begin
					run_len = $urandom_range(60, 130);
				end else begin
					run_len = $urandom_range(1, 25);
				end
				// The last run of a phase stops at the phase budget.
				if (run_len > budget - sent) begin
					run_len = (budget > sent) ? budget - sent : 0;
				end
				repeat (run_len) send_event(tdrp_pkg::OP_ZERO_CROSS, 8'($urandom_range(255)));
				sent += run_len;
			end
			steady_run = 1'b0;
		end
	endtask

	// Status receiver: checks each taken item against the oldest prediction, then picks
	// the ready level for the next edge.
	initial begin
		status_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$display("unexpected status item: delay %0d applied %0d target %0d on %0b",
							firing_delay, applied_power, target_power, is_on);
					end
					mismatch_count++;
				end else begin
					want = expected_status.pop_front();
					if (firing_delay !== want.delay || applied_power !== want.applied ||
						target_power !== want.target || is_on !== want.enabled) begin
						if (mismatch_count < REPORT_LIMIT) begin
							$display("status mismatch at %0t: expected delay %0d applied %0d target %0d on %0b, got delay %0d applied %0d target %0d on %0b",
								$realtime, want.delay, want.applied, want.target, want.enabled,
								firing_delay, applied_power, target_power, is_on);
						end
						mismatch_count++;
					end
				end
			end
			out_ready <= steady_run || ($urandom_range(99) >= 33);
		end
	end

	// Reset is held low at the start and released once; the tests then run in turn.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_power_limits();
		test_switching();
		test_ramp_register();
		test_random_bursts();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: a run that has not finished by 5 ms is reported as failed.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
